FILE: design/arpc_pkg.sv
// ----------------------------------------------------------------------------
// arpc_pkg
// Types, codes and constants shared by the ARP cache and responder modules.
// ----------------------------------------------------------------------------
package arpc_pkg;

    localparam int DEF_ENTRIES = 64;
    localparam int MAX_OUT     = 64;
    localparam int NREQ_W      = $clog2(MAX_OUT + 1);

    // Input item kinds
    localparam logic [1:0] KIND_PACKET = 2'd0;
    localparam logic [1:0] KIND_LOOKUP = 2'd1;
    localparam logic [1:0] KIND_TICK   = 2'd2;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    // Result kinds
    localparam logic [1:0] OUT_ANSWER  = 2'd0;
    localparam logic [1:0] OUT_REQUEST = 2'd1;
    localparam logic [1:0] OUT_REPLY   = 2'd2;

    // Lookup answer status
    localparam logic [1:0] ST_FOUND    = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_PENDING  = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] CFG_OWN_IP        = 3'd0;
    localparam logic [2:0] CFG_OWN_MAC       = 3'd1;
    localparam logic [2:0] CFG_REFRESH_TICKS = 3'd2;
    localparam logic [2:0] CFG_RESOLVE_TICKS = 3'd3;
    localparam logic [2:0] CFG_RETRY_TICKS   = 3'd4;
    localparam logic [2:0] CFG_MAX_ATTEMPTS  = 3'd5;

    localparam logic [23:0] REFRESH_RST = 24'd10000;
    localparam logic [23:0] RESOLVE_RST = 24'd1000;
    localparam logic [23:0] RETRY_RST   = 24'd1000;
    localparam logic [3:0]  MAX_ATT_RST = 4'd3;

    // ARP header values accepted
    localparam logic [15:0] HW_ETHERNET = 16'h0001;
    localparam logic [15:0] PROTO_IPV4  = 16'h0800;
    localparam logic [7:0]  HW_ADDR_LEN = 8'd6;
    localparam logic [7:0]  IP_ADDR_LEN = 8'd4;
    localparam logic [15:0] OP_REQUEST  = 16'd1;
    localparam logic [15:0] OP_REPLY    = 16'd2;

    localparam logic [47:0] BCAST_MAC   = 48'hFFFF_FFFF_FFFF;
    localparam logic [3:0]  RETRIES_MAX = 4'd15;

    // Operations applied by the head unit to the slot passing through it
    localparam logic [1:0] HOP_PASS   = 2'd0;
    localparam logic [1:0] HOP_PACKET = 2'd1;
    localparam logic [1:0] HOP_LOOKUP = 2'd2;
    localparam logic [1:0] HOP_TICK   = 2'd3;

    typedef struct packed {
        logic        used;
        logic        valid;
        logic [3:0]  retries;
        logic        running;
        logic [23:0] left;
        logic [31:0] ip;
        logic [47:0] mac;
    } slot_t;

    typedef struct packed {
        logic [1:0]  op;
        logic        create;
        logic [31:0] sip;
        logic [47:0] smac;
        logic [23:0] refresh_ticks;
        logic [23:0] resolve_ticks;
        logic [23:0] retry_ticks;
        logic [3:0]  max_attempts;
    } head_ctrl_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  status;
        logic [47:0] mac;
        logic [31:0] ip;
    } res_t;

endpackage

FILE: design/arpc_cell.sv
// ----------------------------------------------------------------------------
// arpc_cell
// One table slot of the rotating ring; takes its neighbour's slot on a shift.
// ----------------------------------------------------------------------------
module arpc_cell
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            shift,
    input  arpc_pkg::slot_t d,
    output arpc_pkg::slot_t q
);

    logic        used_reg;
    logic        valid_reg;
    logic [3:0]  retries_reg;
    logic        running_reg;
    logic [23:0] left_reg;
    logic [31:0] ip_reg;
    logic [47:0] mac_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg    <= 1'b0;
            valid_reg   <= 1'b0;
            retries_reg <= '0;
            running_reg <= 1'b0;
            left_reg    <= '0;
        end
        else if (shift)
        begin
            used_reg    <= d.used;
            valid_reg   <= d.valid;
            retries_reg <= d.retries;
            running_reg <= d.running;
            left_reg    <= d.left;
        end
    end

    // Addresses are only read once the slot is in use, so they need no reset.
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            ip_reg  <= d.ip;
            mac_reg <= d.mac;
        end
    end

    assign q = {used_reg, valid_reg, retries_reg, running_reg, left_reg, ip_reg, mac_reg};

endmodule

FILE: design/arpc_head.sv
// ----------------------------------------------------------------------------
// arpc_head
// Update unit at the head of the ring: rewrites the slot leaving cell zero.
// ----------------------------------------------------------------------------
module arpc_head
(
    input  arpc_pkg::head_ctrl_t ctrl,
    input  arpc_pkg::slot_t      slot_in,
    output arpc_pkg::slot_t      slot_out,
    output logic                 req_emit,
    output logic [47:0]          req_mac
);

    logic [3:0] retries_inc;

    assign retries_inc = (slot_in.retries == arpc_pkg::RETRIES_MAX) ?
                         arpc_pkg::RETRIES_MAX : slot_in.retries + 4'd1;
    assign req_mac     = slot_in.valid ? slot_in.mac : arpc_pkg::BCAST_MAC;

    always_comb
    begin
        slot_out = slot_in;
        req_emit = 1'b0;
        unique case (ctrl.op)
            arpc_pkg::HOP_PASS:
            begin
            end
            arpc_pkg::HOP_PACKET:
            begin
                if (ctrl.create)
                begin
                    slot_out.used = 1'b1;
                    slot_out.ip   = ctrl.sip;
                end
                slot_out.mac     = ctrl.smac;
                slot_out.valid   = 1'b1;
                slot_out.retries = '0;
                slot_out.running = 1'b1;
                slot_out.left    = ctrl.refresh_ticks;
            end
            arpc_pkg::HOP_LOOKUP:
            begin
                slot_out.running = 1'b1;
                slot_out.left    = ctrl.resolve_ticks;
            end
            default:
            begin
                if (slot_in.used && slot_in.running)
                begin
                    if (slot_in.left > 24'd1)
                    begin
                        slot_out.left = slot_in.left - 24'd1;
                    end
                    else if (retries_inc >= ctrl.max_attempts)
                    begin
                        // Give up on this entry.
                        slot_out.used    = 1'b0;
                        slot_out.valid   = 1'b0;
                        slot_out.retries = '0;
                        slot_out.running = 1'b0;
                        slot_out.left    = '0;
                    end
                    else
                    begin
                        req_emit         = 1'b1;
                        slot_out.retries = retries_inc;
                        slot_out.running = 1'b1;
                        slot_out.left    = ctrl.retry_ticks;
                    end
                end
            end
        endcase
    end

endmodule

FILE: design/arp_cache_and_responder.sv
// ----------------------------------------------------------------------------
// arp_cache_and_responder
// ARP cache with request responder, lookup port and per-entry timers.
// ----------------------------------------------------------------------------
// The table is a ring of ENTRIES cells that rotates one slot per cycle, while
// a pass runs and is not stalled, past a single update unit. A well-formed
// packet or a lookup takes one search pass, one write-back pass and then hands
// over any results. A tick takes one pass, which stalls while the result side
// holds back requests. One item is worked on at a time; an item is taken only
// when the previous one is finished. Configuration is to be written only while
// idle; the block itself does not enforce this.
module arp_cache_and_responder
#(
    parameter int ENTRIES = arpc_pkg::DEF_ENTRIES
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [47:0] cfg_data,

    input  logic        req_valid,
    output logic        req_ready,
    input  logic [1:0]  kind,
    input  logic        length_ok,
    input  logic [15:0] hw_type,
    input  logic [15:0] proto_type,
    input  logic [7:0]  hw_len,
    input  logic [7:0]  proto_len,
    input  logic [15:0] opcode,
    input  logic [47:0] src_mac,
    input  logic [31:0] src_ip,
    input  logic [31:0] tgt_ip,
    input  logic [31:0] lookup_ip,

    output logic        res_valid,
    input  logic        res_ready,
    output logic [1:0]  out_kind,
    output logic [1:0]  status,
    output logic [47:0] dest_mac,
    output logic [31:0] dest_ip,
    output logic        last
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SEARCH = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_APPLY  = 3'd3;
    localparam logic [2:0] S_EMIT   = 3'd4;
    localparam logic [2:0] S_TICK   = 3'd5;
    localparam logic [2:0] S_FLUSH  = 3'd6;

    // Configuration registers
    logic [31:0] own_ip_reg;
    logic [23:0] refresh_reg;
    logic [23:0] resolve_reg;
    logic [23:0] retry_reg;
    logic [3:0]  max_att_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_ip_reg  <= '0;
            refresh_reg <= arpc_pkg::REFRESH_RST;
            resolve_reg <= arpc_pkg::RESOLVE_RST;
            retry_reg   <= arpc_pkg::RETRY_RST;
            max_att_reg <= arpc_pkg::MAX_ATT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                arpc_pkg::CFG_OWN_IP:        own_ip_reg  <= cfg_data[31:0];
                // Replies are addressed from the sender's fields alone, so the
                // own MAC address is not kept.
                arpc_pkg::CFG_OWN_MAC:
                begin
                end
                arpc_pkg::CFG_REFRESH_TICKS: refresh_reg <= cfg_data[23:0];
                arpc_pkg::CFG_RESOLVE_TICKS: resolve_reg <= cfg_data[23:0];
                arpc_pkg::CFG_RETRY_TICKS:   retry_reg   <= cfg_data[23:0];
                arpc_pkg::CFG_MAX_ATTEMPTS:  max_att_reg <= cfg_data[3:0];
                default:
                begin
                end
            endcase
        end
    end

    // Control registers
    logic [2:0]        state_reg,     state_next;
    logic [IDX_W-1:0]  cnt_reg,       cnt_next;
    logic              found_reg,     found_next;
    logic              free_reg,      free_next;
    logic [IDX_W-1:0]  fidx_reg,      fidx_next;
    logic [IDX_W-1:0]  freeidx_reg,   freeidx_next;
    logic              apply_reg,     apply_next;
    logic              create_reg,    create_next;
    logic [IDX_W-1:0]  tidx_reg,      tidx_next;
    logic [1:0]        nres_reg,      nres_next;
    logic              eidx_reg,      eidx_next;
    logic              held_vld_reg,  held_vld_next;
    logic [arpc_pkg::NREQ_W-1:0] nreq_reg, nreq_next;
    logic              out_vld_reg,   out_vld_next;

    // Payload registers
    logic        is_pkt_reg;
    logic        op_req_reg;
    logic [31:0] key_ip_reg;
    logic [47:0] smac_reg;
    logic [31:0] tip_reg;
    logic        fvalid_reg;
    logic        frunning_reg;
    logic [47:0] fmac_reg;
    arpc_pkg::res_t res0_reg;
    arpc_pkg::res_t res1_reg;
    arpc_pkg::res_t held_reg;
    arpc_pkg::res_t out_reg;
    logic           out_last_reg;

    // Ring of cells and head unit
    arpc_pkg::slot_t     ring_q [ENTRIES];
    arpc_pkg::slot_t     head_out;
    arpc_pkg::head_ctrl_t hctrl;
    logic                shift;
    logic                head_emit;
    logic [47:0]         head_mac;

    for (genvar g = 0; g < ENTRIES; g++)
    begin : g_ring
        if (g == ENTRIES - 1)
        begin : g_tail
            arpc_cell u_cell (.clk(clk), .rst_n(rst_n), .shift(shift),
                              .d(head_out), .q(ring_q[g]));
        end
        else
        begin : g_body
            arpc_cell u_cell (.clk(clk), .rst_n(rst_n), .shift(shift),
                              .d(ring_q[g+1]), .q(ring_q[g]));
        end
    end

    arpc_head u_head
    (
        .ctrl     (hctrl),
        .slot_in  (ring_q[0]),
        .slot_out (head_out),
        .req_emit (head_emit),
        .req_mac  (head_mac)
    );

    logic can_emit;
    logic accept;
    logic pkt_ok;
    logic key_hit;
    logic tick_need;
    logic out_load;
    arpc_pkg::res_t out_data;
    logic           out_data_last;
    logic           decide_en;
    arpc_pkg::res_t new_req;

    assign can_emit  = !out_vld_reg || res_ready;
    assign req_ready = (state_reg == S_IDLE);
    assign accept    = req_valid && req_ready;
    assign pkt_ok    = length_ok && (hw_type == arpc_pkg::HW_ETHERNET) &&
                       (proto_type == arpc_pkg::PROTO_IPV4) &&
                       (hw_len == arpc_pkg::HW_ADDR_LEN) &&
                       (proto_len == arpc_pkg::IP_ADDR_LEN) && !src_mac[40];
    assign key_hit   = ring_q[0].used && (ring_q[0].ip == key_ip_reg);
    assign tick_need = head_emit && (nreq_reg < arpc_pkg::NREQ_W'(arpc_pkg::MAX_OUT));
    assign decide_en = (state_reg == S_DECIDE);

    assign new_req.kind   = arpc_pkg::OUT_REQUEST;
    assign new_req.status = arpc_pkg::ST_FOUND;
    assign new_req.mac    = head_mac;
    assign new_req.ip     = ring_q[0].ip;

    always_comb
    begin
        hctrl.op            = arpc_pkg::HOP_PASS;
        hctrl.create        = create_reg;
        hctrl.sip           = key_ip_reg;
        hctrl.smac          = smac_reg;
        hctrl.refresh_ticks = refresh_reg;
        hctrl.resolve_ticks = resolve_reg;
        hctrl.retry_ticks   = retry_reg;
        hctrl.max_attempts  = max_att_reg;
        if (state_reg == S_TICK)
        begin
            hctrl.op = arpc_pkg::HOP_TICK;
        end
        else if (state_reg == S_APPLY && apply_reg && cnt_reg == tidx_reg)
        begin
            hctrl.op = is_pkt_reg ? arpc_pkg::HOP_PACKET : arpc_pkg::HOP_LOOKUP;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        found_next    = found_reg;
        free_next     = free_reg;
        fidx_next     = fidx_reg;
        freeidx_next  = freeidx_reg;
        apply_next    = apply_reg;
        create_next   = create_reg;
        tidx_next     = tidx_reg;
        nres_next     = nres_reg;
        eidx_next     = eidx_reg;
        held_vld_next = held_vld_reg;
        nreq_next     = nreq_reg;
        shift         = 1'b0;
        out_load      = 1'b0;
        out_data      = res0_reg;
        out_data_last = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                cnt_next   = '0;
                found_next = 1'b0;
                free_next  = 1'b0;
                nreq_next  = '0;
                if (accept)
                begin
                    if (kind == arpc_pkg::KIND_TICK)
                    begin
                        state_next = S_TICK;
                    end
                    else if (kind == arpc_pkg::KIND_LOOKUP ||
                             (kind == arpc_pkg::KIND_PACKET && pkt_ok))
                    begin
                        state_next = S_SEARCH;
                    end
                end
            end
            S_SEARCH:
            begin
                shift    = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (key_hit && !found_reg)
                begin
                    found_next = 1'b1;
                    fidx_next  = cnt_reg;
                end
                if (!ring_q[0].used && !free_reg)
                begin
                    free_next    = 1'b1;
                    freeidx_next = cnt_reg;
                end
                if (cnt_reg == LAST_IDX)
                begin
                    cnt_next   = '0;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                apply_next  = 1'b0;
                create_next = 1'b0;
                tidx_next   = fidx_reg;
                nres_next   = 2'd1;
                eidx_next   = 1'b0;
                state_next  = S_APPLY;
                if (is_pkt_reg)
                begin
                    if (found_reg)
                    begin
                        apply_next = 1'b1;
                    end
                    else if (tip_reg == own_ip_reg && free_reg)
                    begin
                        apply_next  = 1'b1;
                        create_next = 1'b1;
                        tidx_next   = freeidx_reg;
                    end
                    if (!(tip_reg == own_ip_reg && op_req_reg))
                    begin
                        nres_next = 2'd0;
                    end
                end
                else if (found_reg && !fvalid_reg && !frunning_reg)
                begin
                    apply_next = 1'b1;
                    nres_next  = 2'd2;
                end
            end
            S_APPLY:
            begin
                shift    = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_IDX)
                begin
                    cnt_next   = '0;
                    state_next = (nres_reg == 2'd0) ? S_IDLE : S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (can_emit)
                begin
                    out_load      = 1'b1;
                    out_data      = eidx_reg ? res1_reg : res0_reg;
                    out_data_last = (nres_reg == 2'd1) || eidx_reg;
                    eidx_next     = 1'b1;
                    if (out_data_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_TICK:
            begin
                // The previous request is handed on only once a further one
                // appears, so that the final transfer can carry last.
                shift = !(tick_need && held_vld_reg && !can_emit);
                if (tick_need && shift)
                begin
                    out_load      = held_vld_reg;
                    out_data      = held_reg;
                    held_vld_next = 1'b1;
                    nreq_next     = nreq_reg + 1'b1;
                end
                if (shift)
                begin
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == LAST_IDX)
                    begin
                        cnt_next   = '0;
                        state_next = S_FLUSH;
                    end
                end
            end
            S_FLUSH:
            begin
                out_data      = held_reg;
                out_data_last = 1'b1;
                if (!held_vld_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (can_emit)
                begin
                    out_load      = 1'b1;
                    held_vld_next = 1'b0;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        out_vld_next = out_load ? 1'b1 : (res_ready ? 1'b0 : out_vld_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cnt_reg      <= '0;
            found_reg    <= 1'b0;
            free_reg     <= 1'b0;
            fidx_reg     <= '0;
            freeidx_reg  <= '0;
            apply_reg    <= 1'b0;
            create_reg   <= 1'b0;
            tidx_reg     <= '0;
            nres_reg     <= '0;
            eidx_reg     <= 1'b0;
            held_vld_reg <= 1'b0;
            nreq_reg     <= '0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            found_reg    <= found_next;
            free_reg     <= free_next;
            fidx_reg     <= fidx_next;
            freeidx_reg  <= freeidx_next;
            apply_reg    <= apply_next;
            create_reg   <= create_next;
            tidx_reg     <= tidx_next;
            nres_reg     <= nres_next;
            eidx_reg     <= eidx_next;
            held_vld_reg <= held_vld_next;
            nreq_reg     <= nreq_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            is_pkt_reg <= (kind == arpc_pkg::KIND_PACKET);
            op_req_reg <= (opcode == arpc_pkg::OP_REQUEST);
            key_ip_reg <= (kind == arpc_pkg::KIND_PACKET) ? src_ip : lookup_ip;
            smac_reg   <= src_mac;
            tip_reg    <= tgt_ip;
        end
        if (state_reg == S_SEARCH && key_hit && !found_reg)
        begin
            fvalid_reg   <= ring_q[0].valid;
            frunning_reg <= ring_q[0].running;
            fmac_reg     <= ring_q[0].mac;
        end
        if (decide_en)
        begin
            res1_reg.kind   <= arpc_pkg::OUT_ANSWER;
            res1_reg.status <= arpc_pkg::ST_PENDING;
            res1_reg.mac    <= '0;
            res1_reg.ip     <= key_ip_reg;
            res0_reg.ip     <= key_ip_reg;
            if (is_pkt_reg)
            begin
                res0_reg.kind   <= arpc_pkg::OUT_REPLY;
                res0_reg.status <= arpc_pkg::ST_FOUND;
                res0_reg.mac    <= smac_reg;
            end
            else if (!found_reg)
            begin
                res0_reg.kind   <= arpc_pkg::OUT_ANSWER;
                res0_reg.status <= arpc_pkg::ST_NOTFOUND;
                res0_reg.mac    <= '0;
            end
            else if (fvalid_reg)
            begin
                res0_reg.kind   <= arpc_pkg::OUT_ANSWER;
                res0_reg.status <= arpc_pkg::ST_FOUND;
                res0_reg.mac    <= fmac_reg;
            end
            else if (!frunning_reg)
            begin
                res0_reg.kind   <= arpc_pkg::OUT_REQUEST;
                res0_reg.status <= arpc_pkg::ST_FOUND;
                res0_reg.mac    <= arpc_pkg::BCAST_MAC;
            end
            else
            begin
                res0_reg.kind   <= arpc_pkg::OUT_ANSWER;
                res0_reg.status <= arpc_pkg::ST_PENDING;
                res0_reg.mac    <= '0;
            end
        end
        if (state_reg == S_TICK && tick_need && shift)
        begin
            held_reg <= new_req;
        end
        if (out_load)
        begin
            out_reg      <= out_data;
            out_last_reg <= out_data_last;
        end
    end

    assign res_valid = out_vld_reg;
    assign out_kind  = out_reg.kind;
    assign status    = out_reg.status;
    assign dest_mac  = out_reg.mac;
    assign dest_ip   = out_reg.ip;
    assign last      = out_last_reg;

endmodule
